>>> src/ilist_pkg.sv
// ----------------------------------------------------------------------------
// ilist_pkg
// Shared types and codes for the indexed list unit.
// ----------------------------------------------------------------------------
package ilist_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam int COUNT_OUT_W = 7;

  typedef struct packed {
    logic                   ok;
    logic                   full_reject;
    logic [COUNT_OUT_W-1:0] entry_count;
  } res_t;

endpackage

>>> src/ilist_mem.sv
// ----------------------------------------------------------------------------
// ilist_mem
// Entry store: one write port, one read port, registered read data.
// A read and a write to the same address return the old contents.
// ----------------------------------------------------------------------------
module ilist_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/ilist_ctrl.sv
// ----------------------------------------------------------------------------
// ilist_ctrl
// Sequencer for the list: walks the entry store one entry per cycle to
// shift for insert, to search for remove and query, closing gaps on remove.
// ----------------------------------------------------------------------------
module ilist_ctrl #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32,
  parameter int AW         = 6,
  parameter int CW         = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [1:0]            req_type,
  input  logic [6:0]            position,
  input  logic [31:0]           item_value,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ilist_pkg::res_t       res,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [DATA_WIDTH-1:0] mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [DATA_WIDTH-1:0] mem_rdata
);

  import ilist_pkg::*;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [AW-1:0]         pidx_r, pidx_nxt;
  logic                  pend_r, pend_nxt;
  logic                  found_r, found_nxt;
  logic                  first_r, first_nxt;
  logic                  ok_r, ok_nxt;
  logic                  full_r, full_nxt;
  op_t                   op_r, op_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;

  logic [63:0]           val_ext;
  logic                  accept;
  logic                  is_full;
  logic                  pos_bad;
  logic                  walk_last;
  logic                  scan_issue;
  logic                  scan_end;
  op_t                   req_op;

  assign val_ext    = 64'(item_value);
  assign accept     = req_valid && req_ready;
  assign is_full    = (count_r == CW'(CAPACITY));
  assign pos_bad    = (32'(position) > 32'(count_r));
  assign walk_last  = (idx_r == count_r);
  assign scan_issue = (idx_r < count_r);
  assign scan_end   = !scan_issue && !pend_r;
  assign req_op     = op_t'(req_type);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (req_op)
            OP_INSERT: state_nxt = (pos_bad || is_full) ? ST_DONE : ST_INSERT;
            OP_APPEND: state_nxt = is_full ? ST_DONE : ST_INSERT;
            default:   state_nxt = ST_SCAN;
          endcase
        end
      end
      ST_INSERT: if (walk_last) state_nxt = ST_DONE;
      ST_SCAN:   if (scan_end) state_nxt = ST_DONE;
      ST_DONE:   if (res_ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    pend_nxt  = pend_r;
    found_nxt = found_r;
    first_nxt = first_r;
    ok_nxt    = ok_r;
    full_nxt  = full_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    mem_we    = 1'b0;
    mem_waddr = idx_r[AW-1:0];
    mem_wdata = first_r ? val_r : mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = idx_r[AW-1:0];
    req_ready = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (accept) begin
          op_nxt    = req_op;
          val_nxt   = val_ext[DATA_WIDTH-1:0];
          ok_nxt    = 1'b0;
          full_nxt  = 1'b0;
          first_nxt = 1'b1;
          pend_nxt  = 1'b0;
          found_nxt = 1'b0;
          case (req_op)
            OP_INSERT: begin
              full_nxt = !pos_bad && is_full;
              idx_nxt  = CW'(position);
            end
            OP_APPEND: begin
              full_nxt = is_full;
              idx_nxt  = count_r;
            end
            default: idx_nxt = '0;
          endcase
        end
      end
      ST_INSERT: begin
        // write the carried entry, read the one it displaces
        mem_we    = 1'b1;
        mem_re    = 1'b1;
        first_nxt = 1'b0;
        idx_nxt   = idx_r + CW'(1);
        if (walk_last) begin
          count_nxt = count_r + CW'(1);
          ok_nxt    = 1'b1;
        end
      end
      ST_SCAN: begin
        mem_re   = scan_issue;
        pend_nxt = scan_issue;
        if (scan_issue) begin
          idx_nxt  = idx_r + CW'(1);
          pidx_nxt = idx_r[AW-1:0];
        end
        if (pend_r) begin
          if (found_r) begin
            // close the gap (remove only): move each later entry down one slot
            mem_we    = (op_r == OP_REMOVE);
            mem_waddr = pidx_r - AW'(1);
            mem_wdata = mem_rdata;
          end else if (mem_rdata == val_r) begin
            found_nxt = 1'b1;
          end
        end
        if (scan_end) begin
          ok_nxt = found_r;
          if (found_r && (op_r == OP_REMOVE)) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.ok          = ok_r;
  assign res.full_reject = full_r;
  assign res.entry_count = COUNT_OUT_W'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    found_r <= found_nxt;
    first_r <= first_nxt;
    ok_r    <= ok_nxt;
    full_r  <= full_nxt;
    op_r    <= op_nxt;
    val_r   <= val_nxt;
  end

endmodule

>>> src/indexed_list_insert_remove_search_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove_search_unit
// Ordered list of up to CAPACITY words with insert, append, remove-first
// and membership query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request transaction:
//   in_req_type, in_position (insert only) and in_item_value. Each request
//   yields one result transaction on out_valid/out_ready: out_ok,
//   out_full_reject and out_entry_count (count after the request).
//   Walk: an insert at position p walks slots p through count, one per cycle
//   through the single-port-pair entry memory; append writes only the new
//   tail entry; remove and query scan every entry of the list. The result
//   appears as the unit turns ready again, and one request is in flight at
//   a time.
//   Rejected inserts/appends finish without touching the memory.
//   Reset empties the list at once (count cleared); no memory sweep.
//   A stalled receiver holds the result in the output register; the unit
//   then finishes the next request and waits with it until the output frees.
// ----------------------------------------------------------------------------
module indexed_list_insert_remove_search_unit #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_item_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_ok,
  output logic        out_full_reject,
  output logic [6:0]  out_entry_count
);

  import ilist_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                  res_valid;
  logic                  res_ready;
  res_t                  res;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  logic                  out_valid_r;
  res_t                  out_res_r;

  ilist_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_ready  (in_ready),
    .req_type   (in_req_type),
    .position   (in_position),
    .item_value (in_item_value),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  ilist_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register parts the sequencer from the receiver
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_res_r.ok;
  assign out_full_reject = out_res_r.full_reject;
  assign out_entry_count = out_res_r.entry_count;

  a_ok_excl_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_ok && out_full_reject))
    else $error("result reports both success and full refusal");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while another is in progress");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_full_reject) |-> (out_entry_count == 7'(CAPACITY)))
    else $error("full refusal with list not at capacity");

endmodule
